// ===== src/dfe_pkg.sv =====
// ============================================================================
// dfe_pkg
// Types and constants shared by the delimited field extractor modules.
// ============================================================================
package dfe_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 40;
    localparam int unsigned FIELD_W    = 8;
    localparam int unsigned SPEC_W     = 16;
    localparam int unsigned IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DELIM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEC0 = 3'd2;

    localparam logic [7:0]         DELIM_RESET = 8'd44;
    localparam logic [FIELD_W-1:0] FIELD_MAX   = 8'd255;
    localparam logic [FIELD_W-1:0] FIELD_FIRST = 8'd1;

    typedef struct packed {
        logic [SPEC_W-1:0]  len;
        logic [SPEC_W-1:0]  off;
        logic [FIELD_W-1:0] fld;
    } t_spec;

    localparam t_spec SPEC_RESET = '{len: '0, off: '0, fld: FIELD_FIRST};

    typedef struct packed {
        logic valid;
        logic last;
        logic found;
        logic stop_seen;
    } t_slot_ctl;

endpackage

// ===== src/dfe_cell.sv =====
// ============================================================================
// dfe_cell
// Field tracking cell: records start and stop position of one spec's field.
// ============================================================================
module dfe_cell #(
    parameter int unsigned POS_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_clear,
    input  logic             i_match,
    input  logic             i_delim,
    input  logic [POS_W-1:0] i_pos,
    output logic             o_start_seen,
    output logic [POS_W-1:0] o_start,
    output logic             o_stop_seen,
    output logic [POS_W-1:0] o_stop
);

    logic             r_start_seen, n_start_seen;
    logic             r_stop_seen, n_stop_seen;
    logic [POS_W-1:0] r_start, n_start;
    logic [POS_W-1:0] r_stop, n_stop;

    always_comb begin
        n_start_seen = r_start_seen;
        n_start      = r_start;
        n_stop_seen  = r_stop_seen;
        n_stop       = r_stop;
        if (i_step && i_match) begin
            if (!r_start_seen) begin
                n_start_seen = 1'b1;
                n_start      = i_pos;
            end
            if (i_delim && !r_stop_seen) begin
                n_stop_seen = 1'b1;
                n_stop      = i_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_start_seen <= 1'b0;
            r_stop_seen  <= 1'b0;
        end else begin
            r_start_seen <= n_start_seen;
            r_stop_seen  <= n_stop_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_stop  <= n_stop;
    end

    assign o_start_seen = n_start_seen;
    assign o_start      = n_start;
    assign o_stop_seen  = n_stop_seen;
    assign o_stop       = n_stop;

endmodule

// ===== src/dfe_slot.sv =====
// ============================================================================
// dfe_slot
// Result slot: loads one spec's line result at line end, then shifts toward
// the output head.
// ============================================================================
module dfe_slot #(
    parameter int unsigned POS_W = 13
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic                       i_shift,
    input  logic                       i_ld_valid,
    input  logic                       i_ld_last,
    input  logic [dfe_pkg::IDX_W-1:0]  i_ld_idx,
    input  logic                       i_ld_seen,
    input  logic [POS_W-1:0]           i_ld_start,
    input  logic                       i_ld_stop_seen,
    input  logic [POS_W-1:0]           i_ld_stop,
    input  logic [dfe_pkg::SPEC_W-1:0] i_ld_off,
    input  logic [dfe_pkg::SPEC_W-1:0] i_ld_len,
    input  logic [POS_W-1:0]           i_ld_end,
    output logic                       o_ld_found,
    input  dfe_pkg::t_slot_ctl         i_nx_ctl,
    input  logic [dfe_pkg::IDX_W-1:0]  i_nx_idx,
    input  logic [POS_W-1:0]           i_nx_a0,
    input  logic [dfe_pkg::SPEC_W-1:0] i_nx_len,
    input  logic [POS_W-1:0]           i_nx_stop,
    output dfe_pkg::t_slot_ctl         o_ctl,
    output logic [dfe_pkg::IDX_W-1:0]  o_idx,
    output logic [POS_W-1:0]           o_a0,
    output logic [dfe_pkg::SPEC_W-1:0] o_len,
    output logic [POS_W-1:0]           o_stop
);
    import dfe_pkg::*;

    localparam int unsigned SUM_W = ((POS_W > SPEC_W) ? POS_W : SPEC_W) + 1;

    t_slot_ctl         r_ctl;
    logic [IDX_W-1:0]  r_idx;
    logic [POS_W-1:0]  r_a0;
    logic [SPEC_W-1:0] r_len;
    logic [POS_W-1:0]  r_stop;
    logic [SUM_W-1:0]  w_a0;

    assign w_a0       = SUM_W'(i_ld_start) + SUM_W'(i_ld_off);
    assign o_ld_found = i_ld_seen && (w_a0 <= SUM_W'(i_ld_end));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_load) begin
            r_ctl <= '{valid: i_ld_valid, last: i_ld_last, found: o_ld_found,
                       stop_seen: i_ld_stop_seen};
        end else if (i_shift) begin
            r_ctl <= i_nx_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_idx  <= i_ld_idx;
            r_a0   <= w_a0[POS_W-1:0];
            r_len  <= i_ld_len;
            r_stop <= i_ld_stop;
        end else if (i_shift) begin
            r_idx  <= i_nx_idx;
            r_a0   <= i_nx_a0;
            r_len  <= i_nx_len;
            r_stop <= i_nx_stop;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_idx  = r_idx;
    assign o_a0   = r_a0;
    assign o_len  = r_len;
    assign o_stop = r_stop;

endmodule

// ===== src/delimited_field_extractor.sv =====
// ============================================================================
// delimited_field_extractor
// Splits a byte stream into delimited fields and reports, at each line end,
// the start and stop positions selected by up to NUM_SPECS field specs.
// ============================================================================
// Throughput: one byte transaction per cycle while o_ready is high; results
// leave one per cycle while i_ready is high. The first result of a line is
// loaded into the result slots, then registered at the output. A line-end
// transaction waits only while the chain holds results of the previous line.
// Reset: synchronous, active low; control registers reset, datapath ones do not.
module delimited_field_extractor #(
    parameter int unsigned NUM_SPECS   = 6,
    parameter int unsigned LINE_LENGTH = 4096,
    localparam int unsigned POS_W      = $clog2(LINE_LENGTH + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dfe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dfe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_text_byte,
    input  logic                           i_has_byte,
    input  logic                           i_line_end,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [dfe_pkg::IDX_W-1:0]      o_spec_index,
    output logic                           o_found,
    output logic [POS_W-1:0]               o_start_pos,
    output logic [POS_W-1:0]               o_stop_pos,
    output logic [dfe_pkg::IDX_W-1:0]      o_used_count,
    output logic                           o_last_result
);
    import dfe_pkg::*;

    localparam int unsigned SUM_W = ((POS_W > SPEC_W) ? POS_W : SPEC_W) + 1;

    logic [7:0]         r_delim;
    logic [2:0]         r_count;
    t_spec              r_spec [NUM_SPECS];
    logic [FIELD_W-1:0] r_fc, n_fc;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [POS_W-1:0]   r_end;
    logic [IDX_W-1:0]   r_used, n_used;

    logic       w_acc, w_step, w_clear, w_is_delim, w_free, w_shift;
    logic [2:0] w_count;

    logic [NUM_SPECS-1:0] w_seen, w_stop_seen, w_found;
    logic [POS_W-1:0]     w_start [NUM_SPECS];
    logic [POS_W-1:0]     w_stop  [NUM_SPECS];

    t_slot_ctl         s_ctl  [NUM_SPECS+1];
    logic [IDX_W-1:0]  s_idx  [NUM_SPECS+1];
    logic [POS_W-1:0]  s_a0   [NUM_SPECS+1];
    logic [SPEC_W-1:0] s_len  [NUM_SPECS+1];
    logic [POS_W-1:0]  s_stop [NUM_SPECS+1];

    logic [SUM_W-1:0] w_sum;
    logic [POS_W-1:0] w_a1;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
            r_count <= '0;
            for (int i = 0; i < NUM_SPECS; i++) begin
                r_spec[i] <= SPEC_RESET;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_DELIM) begin
                r_delim <= i_cfg_data[7:0];
            end
            if (i_cfg_index == REG_COUNT) begin
                r_count <= i_cfg_data[2:0];
            end
            for (int i = 0; i < NUM_SPECS; i++) begin
                if (i_cfg_index == REG_SPEC0 + CFG_IDX_W'(i)) begin
                    r_spec[i] <= i_cfg_data;
                end
            end
        end
    end

    assign w_count = (r_count > 3'(NUM_SPECS)) ? 3'(NUM_SPECS) : r_count;

    // input handshake
    assign w_shift    = s_ctl[0].valid && (!o_valid || i_ready);
    assign w_free     = !s_ctl[0].valid || (w_shift && !s_ctl[1].valid);
    assign o_ready    = !i_line_end || w_free;
    assign w_acc      = i_valid && o_ready;
    assign w_step     = w_acc && i_has_byte;
    assign w_clear    = w_acc && i_line_end;
    assign w_is_delim = (i_text_byte == r_delim);

    always_comb begin
        n_fc  = r_fc;
        n_pos = r_pos;
        if (w_step) begin
            if (w_is_delim && r_fc != FIELD_MAX) begin
                n_fc = r_fc + FIELD_W'(1);
            end
            if (r_pos < POS_W'(LINE_LENGTH)) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_fc  <= FIELD_FIRST;
            r_pos <= '0;
        end else begin
            r_fc  <= n_fc;
            r_pos <= n_pos;
        end
    end

    // tracking cells and result slots
    assign s_ctl[NUM_SPECS]  = '0;
    assign s_idx[NUM_SPECS]  = '0;
    assign s_a0[NUM_SPECS]   = '0;
    assign s_len[NUM_SPECS]  = '0;
    assign s_stop[NUM_SPECS] = '0;

    for (genvar g = 0; g < NUM_SPECS; g++) begin : g_spec
        logic w_match;

        assign w_match = (r_fc == ((r_spec[g].fld == '0) ? FIELD_FIRST : r_spec[g].fld));

        dfe_cell #(
            .POS_W(POS_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_step      (w_step),
            .i_clear     (w_clear),
            .i_match     (w_match),
            .i_delim     (w_is_delim),
            .i_pos       (r_pos),
            .o_start_seen(w_seen[g]),
            .o_start     (w_start[g]),
            .o_stop_seen (w_stop_seen[g]),
            .o_stop      (w_stop[g])
        );

        dfe_slot #(
            .POS_W(POS_W)
        ) u_slot (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_load        (w_clear),
            .i_shift       (w_shift),
            .i_ld_valid    (3'(g) < w_count),
            .i_ld_last     (3'(g + 1) == w_count),
            .i_ld_idx      (IDX_W'(g)),
            .i_ld_seen     (w_seen[g]),
            .i_ld_start    (w_start[g]),
            .i_ld_stop_seen(w_stop_seen[g]),
            .i_ld_stop     (w_stop[g]),
            .i_ld_off      (r_spec[g].off),
            .i_ld_len      (r_spec[g].len),
            .i_ld_end      (n_pos),
            .o_ld_found    (w_found[g]),
            .i_nx_ctl      (s_ctl[g+1]),
            .i_nx_idx      (s_idx[g+1]),
            .i_nx_a0       (s_a0[g+1]),
            .i_nx_len      (s_len[g+1]),
            .i_nx_stop     (s_stop[g+1]),
            .o_ctl         (s_ctl[g]),
            .o_idx         (s_idx[g]),
            .o_a0          (s_a0[g]),
            .o_len         (s_len[g]),
            .o_stop        (s_stop[g])
        );
    end

    always_comb begin
        n_used = '0;
        for (int i = 0; i < NUM_SPECS; i++) begin
            if (3'(i) < w_count && w_found[i]) begin
                n_used = IDX_W'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_clear) begin
            r_end  <= n_pos;
            r_used <= n_used;
        end
    end

    // head of chain: stop position and output register
    assign w_sum = SUM_W'(s_a0[0]) + SUM_W'(s_len[0]);

    always_comb begin
        if (s_len[0] != '0) begin
            w_a1 = (w_sum > SUM_W'(r_end)) ? r_end : w_sum[POS_W-1:0];
        end else begin
            w_a1 = s_ctl[0].stop_seen ? s_stop[0] : r_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_shift) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            o_spec_index  <= s_idx[0];
            o_found       <= s_ctl[0].found;
            o_start_pos   <= s_ctl[0].found ? s_a0[0] : '0;
            o_stop_pos    <= s_ctl[0].found ? w_a1 : '0;
            o_used_count  <= r_used;
            o_last_result <= s_ctl[0].last;
        end
    end

endmodule
